// File: rtl/bitmap_page_allocator_macros.svh
// Assertion macros for the checker file of the page allocator.
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BPA_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("bpa check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BPA_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("bpa check failed");

`endif

// File: rtl/bpa_pkg.sv
// Shared types and constants of the bitmap page allocator.
`timescale 1ns / 1ps
package bpa_pkg;
   localparam int MAX_PAGES_DEF     = 4096;
   localparam int MAP_WORD_BITS_DEF = 64;
   localparam int PAGE_W            = 40;
   localparam int COUNT_W           = 13;
   localparam int SUM_W             = 64;

   localparam logic [COUNT_W-1:0] SEG_PAGES_RESET = 13'd4096;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic REG_BASE  = 1'b0;
   localparam logic REG_PAGES = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_BIT,
      ST_FREE_PREP,
      ST_MARK_RD,
      ST_MARK_WR
   } state_type;
endpackage

// File: rtl/bpa_map_ram.sv
// Used-page map memory: one address shared by writes and registered reads, per-word valid bits.
`timescale 1ns / 1ps
module bpa_map_ram #(
   parameter int WORDS = 64,
   parameter int WIDTH = 64,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [AW-1:0]    addr,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [WORDS];
   logic [WORDS-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   // A word never written since reset reads as all pages free.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= valid_ff[addr] ? mem[addr] : '0;
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: command sequencer around the used-page map.
`timescale 1ns / 1ps
// The block keeps one used bit per page of a segment in a word-wide map memory
// and runs one command at a time; busy is high while a command is at work.
// An allocate command walks the map one page per cycle from page 0, pausing in
// a read state at each word boundary for the memory read, until a fitting run
// is found or the segment or limit ends; the taken run is then marked in a
// read-modify-write pass over the words from word 0 up to the run's end, with a
// read state and a write state per word. A free command first clips its range
// in a prep state and then runs the same marking pass. A zero-page command
// answers in the next cycle. Each result shows for exactly one cycle with
// rsp_valid high; the receiver cannot stall, so it must take every result in
// the cycle it appears.
module bitmap_page_allocator
   import bpa_pkg::*;
#(
   parameter int MAX_PAGES     = MAX_PAGES_DEF,
   parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [PAGE_W-1:0]  csr_wdata,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic [COUNT_W-1:0] req_request_pages,
   input  logic               req_need_contiguous,
   input  logic [PAGE_W-1:0]  req_limit_page,
   input  logic [PAGE_W-1:0]  req_release_page,
   output logic               rsp_valid,
   output logic               rsp_granted,
   output logic [PAGE_W-1:0]  rsp_first_page,
   output logic [COUNT_W-1:0] rsp_page_count
);
   localparam int WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int PG_W  = $clog2(MAX_PAGES + 1);
   localparam int CW    = (PG_W > COUNT_W) ? PG_W : COUNT_W;
   localparam int BI_W  = $clog2(MAP_WORD_BITS);
   localparam int BW    = $clog2(WORDS * MAP_WORD_BITS + MAP_WORD_BITS + 1);

   state_type state_ff, state_in;

   logic [PAGE_W-1:0]  seg_base_ff, seg_base_in;
   logic [COUNT_W-1:0] seg_pages_ff, seg_pages_in;

   logic [COUNT_W-1:0] req_ff, req_in;
   logic               cont_ff, cont_in;
   logic [PAGE_W-1:0]  limit_ff, limit_in;
   logic [PAGE_W-1:0]  rel_ff, rel_in;

   logic [PG_W-1:0] pg_ff, pg_in;
   logic [BI_W-1:0] bit_ff, bit_in;
   logic [AW-1:0]   word_ff, word_in;
   logic            in_run_ff, in_run_in;
   logic [PG_W-1:0] run_start_ff, run_start_in;

   logic [PG_W-1:0] mark_lo_ff, mark_lo_in;
   logic [PG_W-1:0] mark_hi_ff, mark_hi_in;
   logic            mark_set_ff, mark_set_in;
   logic [BW-1:0]   wb_ff, wb_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_granted_ff, rsp_granted_in;
   logic [PAGE_W-1:0]  rsp_first_ff, rsp_first_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [MAP_WORD_BITS-1:0] rd_data;
   logic [MAP_WORD_BITS-1:0] wr_data;
   logic [MAP_WORD_BITS-1:0] mark_mask;
   logic                     wr_en;

   logic [CW-1:0]   seg_ext;
   logic [PG_W-1:0] seg_len;
   logic [PG_W-1:0] run_len;
   logic            in_bound;
   logic [SUM_W-1:0] abs_pg;
   logic [SUM_W-1:0] free_lo, free_hi, seg_lo, seg_hi;

   bpa_map_ram #(
      .WORDS (WORDS),
      .WIDTH (MAP_WORD_BITS),
      .AW    (AW)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .addr    (word_ff),
      .wr_en   (wr_en),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   assign seg_ext = CW'(seg_pages_ff);
   assign seg_len = (seg_ext > CW'(MAX_PAGES)) ? PG_W'(MAX_PAGES) : PG_W'(seg_ext);
   assign run_len = pg_ff - run_start_ff;
   assign abs_pg  = SUM_W'(seg_base_ff) + SUM_W'(pg_ff);
   assign in_bound = (pg_ff < seg_len) &&
                     ((limit_ff == '0) || (abs_pg < SUM_W'(limit_ff)));

   assign seg_lo  = SUM_W'(seg_base_ff);
   assign seg_hi  = SUM_W'(seg_base_ff) + SUM_W'(seg_len);
   assign free_lo = (SUM_W'(rel_ff) < seg_lo) ? seg_lo : SUM_W'(rel_ff);
   assign free_hi = ((SUM_W'(rel_ff) + SUM_W'(req_ff)) > seg_hi) ? seg_hi :
                    (SUM_W'(rel_ff) + SUM_W'(req_ff));

   always_comb begin
      for (int i = 0; i < MAP_WORD_BITS; i++) begin
         mark_mask[i] = ((wb_ff + BW'(i)) >= BW'(mark_lo_ff)) &&
                        ((wb_ff + BW'(i)) < BW'(mark_hi_ff));
      end
   end

   assign wr_data = mark_set_ff ? (rd_data | mark_mask) : (rd_data & ~mark_mask);
   assign wr_en   = (state_ff == ST_MARK_WR);

   always_comb begin
      seg_base_in  = seg_base_ff;
      seg_pages_in = seg_pages_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_BASE:  seg_base_in  = csr_wdata;
            REG_PAGES: seg_pages_in = csr_wdata[COUNT_W-1:0];
            default:   seg_base_in  = seg_base_ff;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      cont_in        = cont_ff;
      limit_in       = limit_ff;
      rel_in         = rel_ff;
      pg_in          = pg_ff;
      bit_in         = bit_ff;
      word_in        = word_ff;
      in_run_in      = in_run_ff;
      run_start_in   = run_start_ff;
      mark_lo_in     = mark_lo_ff;
      mark_hi_in     = mark_hi_ff;
      mark_set_in    = mark_set_ff;
      wb_in          = wb_ff;
      rsp_valid_in   = 1'b0;
      rsp_granted_in = rsp_granted_ff;
      rsp_first_in   = rsp_first_ff;
      rsp_count_in   = rsp_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in    = req_request_pages;
               cont_in   = req_need_contiguous;
               limit_in  = req_limit_page;
               rel_in    = req_release_page;
               pg_in     = '0;
               bit_in    = '0;
               word_in   = '0;
               wb_in     = '0;
               in_run_in = 1'b0;
               if (req_request_pages == '0) begin
                  rsp_valid_in   = 1'b1;
                  rsp_granted_in = 1'b0;
                  rsp_first_in   = '0;
                  rsp_count_in   = '0;
               end else if (req_command == CMD_ALLOC) begin
                  state_in = ST_SCAN_RD;
               end else begin
                  state_in = ST_FREE_PREP;
               end
            end
         end

         ST_SCAN_RD: begin
            state_in = ST_SCAN_BIT;
         end

         ST_SCAN_BIT: begin
            priority if (!in_bound) begin
               // The scan ran off the segment or the limit; an open run still counts
               // when partial runs are allowed or when it already reached full size.
               if (in_run_ff && (!cont_ff || (CW'(run_len) == CW'(req_ff)))) begin
                  rsp_granted_in = 1'b1;
                  rsp_first_in   = PAGE_W'(seg_lo + SUM_W'(run_start_ff));
                  rsp_count_in   = COUNT_W'(run_len);
                  mark_lo_in     = run_start_ff;
                  mark_hi_in     = pg_ff;
                  mark_set_in    = 1'b1;
                  word_in        = '0;
                  state_in       = ST_MARK_RD;
               end else begin
                  rsp_valid_in   = 1'b1;
                  rsp_granted_in = 1'b0;
                  rsp_first_in   = '0;
                  rsp_count_in   = '0;
                  state_in       = ST_IDLE;
               end
            end else if (in_run_ff && (CW'(run_len) == CW'(req_ff))) begin
               rsp_granted_in = 1'b1;
               rsp_first_in   = PAGE_W'(seg_lo + SUM_W'(run_start_ff));
               rsp_count_in   = req_ff;
               mark_lo_in     = run_start_ff;
               mark_hi_in     = pg_ff;
               mark_set_in    = 1'b1;
               word_in        = '0;
               state_in       = ST_MARK_RD;
            end else if (rd_data[bit_ff] && in_run_ff && !cont_ff) begin
               rsp_granted_in = 1'b1;
               rsp_first_in   = PAGE_W'(seg_lo + SUM_W'(run_start_ff));
               rsp_count_in   = COUNT_W'(run_len);
               mark_lo_in     = run_start_ff;
               mark_hi_in     = pg_ff;
               mark_set_in    = 1'b1;
               word_in        = '0;
               state_in       = ST_MARK_RD;
            end else begin
               if (rd_data[bit_ff]) begin
                  in_run_in = 1'b0;
               end else if (!in_run_ff) begin
                  in_run_in    = 1'b1;
                  run_start_in = pg_ff;
               end
               pg_in = pg_ff + PG_W'(1);
               if (bit_ff == BI_W'(MAP_WORD_BITS - 1)) begin
                  bit_in   = '0;
                  word_in  = word_ff + AW'(1);
                  state_in = ST_SCAN_RD;
               end else begin
                  bit_in = bit_ff + BI_W'(1);
               end
            end
         end

         ST_FREE_PREP: begin
            if (free_lo < free_hi) begin
               rsp_granted_in = 1'b1;
               rsp_first_in   = PAGE_W'(free_lo);
               rsp_count_in   = COUNT_W'(free_hi - free_lo);
               mark_lo_in     = PG_W'(free_lo - seg_lo);
               mark_hi_in     = PG_W'(free_hi - seg_lo);
               mark_set_in    = 1'b0;
               state_in       = ST_MARK_RD;
            end else begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = 1'b0;
               rsp_first_in   = '0;
               rsp_count_in   = '0;
               state_in       = ST_IDLE;
            end
         end

         ST_MARK_RD: begin
            state_in = ST_MARK_WR;
         end

         ST_MARK_WR: begin
            wb_in   = wb_ff + BW'(MAP_WORD_BITS);
            word_in = word_ff + AW'(1);
            if ((wb_ff + BW'(MAP_WORD_BITS)) >= BW'(mark_hi_ff)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_MARK_RD;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seg_base_ff  <= '0;
         seg_pages_ff <= SEG_PAGES_RESET;
         rsp_valid_ff <= 1'b0;
         in_run_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_base_ff  <= seg_base_in;
         seg_pages_ff <= seg_pages_in;
         rsp_valid_ff <= rsp_valid_in;
         in_run_ff    <= in_run_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      cont_ff        <= cont_in;
      limit_ff       <= limit_in;
      rel_ff         <= rel_in;
      pg_ff          <= pg_in;
      bit_ff         <= bit_in;
      word_ff        <= word_in;
      run_start_ff   <= run_start_in;
      mark_lo_ff     <= mark_lo_in;
      mark_hi_ff     <= mark_hi_in;
      mark_set_ff    <= mark_set_in;
      wb_ff          <= wb_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_first_ff   <= rsp_first_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted    = rsp_granted_ff;
   assign rsp_first_page = rsp_first_ff;
   assign rsp_page_count = rsp_count_ff;
endmodule

// File: rtl/bpa_checker.sv
// Port-level checks of the bitmap page allocator and their bind.
`timescale 1ns / 1ps
`include "bitmap_page_allocator_macros.svh"
module bpa_checker
   import bpa_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [COUNT_W-1:0] req_request_pages,
   input logic               rsp_valid,
   input logic               rsp_granted,
   input logic [PAGE_W-1:0]  rsp_first_page,
   input logic [COUNT_W-1:0] rsp_page_count
);
   // A refused command carries an all-zero beat.
   `BPA_ASSERT_NOW(a_refused_zero, rsp_valid && !rsp_granted, (rsp_first_page == '0) && (rsp_page_count == '0))
   // A granted beat always moves at least one page.
   `BPA_ASSERT_NOW(a_granted_count, rsp_valid && rsp_granted, rsp_page_count != '0)
   // A zero-page command is refused in the next cycle.
   `BPA_ASSERT_NEXT(a_zero_request, start && !busy && (req_request_pages == '0), rsp_valid && !rsp_granted)
   // Every command that ends its work delivers its beat as busy drops.
   `BPA_ASSERT_NOW(a_done_beat, $fell(busy), rsp_valid)
   // A result beat is never shown while a command is still at work.
   `BPA_ASSERT_NOW(a_beat_idle, rsp_valid, !busy)
endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_request_pages (req_request_pages),
   .rsp_valid         (rsp_valid),
   .rsp_granted       (rsp_granted),
   .rsp_first_page    (rsp_first_page),
   .rsp_page_count    (rsp_page_count)
);

// File: tb/sv/bitmap_page_allocator_test.sv
// Self-checking testbench for the bitmap page allocator.
`timescale 1ns / 1ps
module bitmap_page_allocator_test;
   import bpa_pkg::*;

   typedef struct {
      logic               command;
      logic [COUNT_W-1:0] pages;
      logic               contig;
      logic [PAGE_W-1:0]  lim_page;
      logic [PAGE_W-1:0]  rel_page;
   } page_cmd_type;

   typedef struct {
      logic               granted;
      logic [PAGE_W-1:0]  first_page;
      logic [COUNT_W-1:0] page_count;
   } grant_type;

   typedef struct {
      page_cmd_type cmd;
      bit           known;
      grant_type    answer;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic               csr_index;
   logic [PAGE_W-1:0]  csr_wdata;
   logic               start;
   logic               busy;
   logic               req_command;
   logic [COUNT_W-1:0] req_request_pages;
   logic               req_need_contiguous;
   logic [PAGE_W-1:0]  req_limit_page;
   logic [PAGE_W-1:0]  req_release_page;
   logic               rsp_valid;
   logic               rsp_granted;
   logic [PAGE_W-1:0]  rsp_first_page;
   logic [COUNT_W-1:0] rsp_page_count;

   // Shadow copy of the allocator state.
   bit [MAX_PAGES_DEF-1:0] shadow_used;
   longint unsigned        shadow_base;
   longint unsigned        shadow_pages;

   grant_type    pending_grants[$];
   stim_row_type directed_rows[$];
   int           error_count;

   bitmap_page_allocator u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_request_pages   (req_request_pages),
      .req_need_contiguous (req_need_contiguous),
      .req_limit_page      (req_limit_page),
      .req_release_page    (req_release_page),
      .rsp_valid           (rsp_valid),
      .rsp_granted         (rsp_granted),
      .rsp_first_page      (rsp_first_page),
      .rsp_page_count      (rsp_page_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic longint unsigned active_pages();
      return (shadow_pages > MAX_PAGES_DEF) ? MAX_PAGES_DEF : shadow_pages;
   endfunction

   function automatic bit under_limit(longint unsigned pg, longint unsigned lim);
      return lim == 0 || shadow_base + pg < lim;
   endfunction

   // Computes the answer to one command and updates the shadow map.
   function automatic grant_type allocate_or_free(page_cmd_type c);
      longint unsigned seg, pg, run_start, run_len, want, lim, lo, hi;
      bit ok;
      grant_type g;
      seg = active_pages();
      want = 64'(c.pages);
      lim = 64'(c.lim_page);
      ok = 0;
      run_start = 0;
      run_len = 0;
      if (want != 0 && c.command == CMD_ALLOC) begin
         pg = 0;
         while (pg < seg && under_limit(pg, lim)) begin
            if (shadow_used[pg]) begin
               pg++;
               continue;
            end
            run_start = pg;
            while (pg < seg && under_limit(pg, lim) && pg - run_start < want
                   && !shadow_used[pg])
               pg++;
            run_len = pg - run_start;
            if (!c.contig || run_len >= want) begin
               ok = 1;
               break;
            end
         end
         if (ok) begin
            for (pg = run_start; pg < run_start + run_len; pg++)
               shadow_used[pg] = 1'b1;
            run_start = shadow_base + run_start;
         end
      end else if (want != 0) begin
         lo = 64'(c.rel_page);
         hi = lo + want;
         if (lo < shadow_base)
            lo = shadow_base;
         if (hi > shadow_base + seg)
            hi = shadow_base + seg;
         if (lo < hi) begin
            for (pg = lo - shadow_base; pg < hi - shadow_base; pg++)
               shadow_used[pg] = 1'b0;
            run_start = lo;
            run_len = hi - lo;
            ok = 1;
         end
      end
      if (!ok || run_len == 0) begin
         g.granted = 1'b0;
         g.first_page = '0;
         g.page_count = '0;
      end else begin
         g.granted = 1'b1;
         g.first_page = run_start[PAGE_W-1:0];
         g.page_count = run_len[COUNT_W-1:0];
      end
      return g;
   endfunction

   function automatic page_cmd_type random_cmd();
      page_cmd_type c;
      longint unsigned seg;
      int sel;
      seg = active_pages();
      c.command = ($urandom_range(0, 99) < 60) ? CMD_ALLOC : CMD_FREE;
      c.contig = 1'($urandom_range(0, 1));
      sel = $urandom_range(0, 99);
      if (sel < 4)
         c.pages = '0;
      else if (sel < 12)
         c.pages = COUNT_W'($urandom);
      else if (c.command == CMD_FREE)
         c.pages = COUNT_W'($urandom_range(1, (seg > 0) ? seg : 1));
      else
         c.pages = COUNT_W'($urandom_range(1, (seg > 64) ? 64 : seg + 2));
      sel = $urandom_range(0, 99);
      if (sel < 60)
         c.lim_page = '0;
      else if (sel < 90)
         c.lim_page = PAGE_W'(shadow_base + $urandom_range(0, seg + 10));
      else
         c.lim_page = PAGE_W'({$urandom, $urandom});
      if ($urandom_range(0, 99) < 70)
         c.rel_page = PAGE_W'(shadow_base + $urandom_range(0, seg + 8) - 4);
      else
         c.rel_page = PAGE_W'({$urandom, $urandom});
      return c;
   endfunction

   function automatic void add_row(logic command, int pages, logic contig,
                                   longint unsigned lim, longint unsigned rel,
                                   bit known, logic granted,
                                   longint unsigned first, int count);
      stim_row_type r;
      r.cmd.command = command;
      r.cmd.pages = COUNT_W'(pages);
      r.cmd.contig = contig;
      r.cmd.lim_page = PAGE_W'(lim);
      r.cmd.rel_page = PAGE_W'(rel);
      r.known = known;
      r.answer.granted = granted;
      r.answer.first_page = PAGE_W'(first);
      r.answer.page_count = COUNT_W'(count);
      directed_rows.push_back(r);
   endfunction

   task automatic write_csr(logic index, logic [PAGE_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == REG_BASE)
         shadow_base = 64'(value);
      else
         shadow_pages = 64'(value[COUNT_W-1:0]);
      @(posedge clock);
   endtask

   // Drives one command beat and holds it until the block takes it.
   task automatic send_cmd(page_cmd_type c, bit known, grant_type answer);
      grant_type g;
      req_command <= c.command;
      req_request_pages <= c.pages;
      req_need_contiguous <= c.contig;
      req_limit_page <= c.lim_page;
      req_release_page <= c.rel_page;
      start <= 1'b1;
      do
         @(posedge clock);
      while (busy);
      g = allocate_or_free(c);
      pending_grants.push_back(known ? answer : g);
   endtask

   task automatic idle_gap(bit allow);
      if (allow && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_grants.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   always @(posedge clock) begin
      grant_type exp_g;
      if (!reset && rsp_valid) begin
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected result granted=%0d first=%0h count=%0d",
                     $time, rsp_granted, rsp_first_page, rsp_page_count);
            error_count++;
         end else begin
            exp_g = pending_grants.pop_front();
            if (rsp_granted !== exp_g.granted) begin
               $display("%0t: granted expected %0d actual %0d",
                        $time, exp_g.granted, rsp_granted);
               error_count++;
            end
            if (rsp_first_page !== exp_g.first_page) begin
               $display("%0t: first_page expected %0h actual %0h",
                        $time, exp_g.first_page, rsp_first_page);
               error_count++;
            end
            if (rsp_page_count !== exp_g.page_count) begin
               $display("%0t: page_count expected %0d actual %0d",
                        $time, exp_g.page_count, rsp_page_count);
               error_count++;
            end
         end
      end
   end

   initial begin
      grant_type none;
      page_cmd_type c;
      longint unsigned top_page;
      int n_items;
      logic [PAGE_W-1:0] base_val, pages_val;
      top_page = 64'hFF_FFFF_FFFF;
      none.granted = 1'b0;
      none.first_page = '0;
      none.page_count = '0;
      error_count = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = REG_BASE;
      csr_wdata = '0;
      start = 1'b0;
      req_command = CMD_ALLOC;
      req_request_pages = '0;
      req_need_contiguous = 1'b0;
      req_limit_page = '0;
      req_release_page = '0;
      shadow_used = '0;
      shadow_base = 0;
      shadow_pages = 64'(SEG_PAGES_RESET);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed commands on the reset segment: base 0, 4096 pages.
      add_row(CMD_ALLOC, 1, 0, 0, 0, 1, 1, 0, 1);
      add_row(CMD_ALLOC, 0, 0, 0, 0, 1, 0, 0, 0);
      add_row(CMD_FREE, 0, 0, 0, 0, 1, 0, 0, 0);
      add_row(CMD_ALLOC, 8191, 0, 0, 0, 1, 1, 1, 4095);
      add_row(CMD_ALLOC, 1, 1, 0, 0, 1, 0, 0, 0);
      add_row(CMD_FREE, 8191, 0, 0, 0, 1, 1, 0, 4096);
      add_row(CMD_ALLOC, 4097, 1, 0, 0, 1, 0, 0, 0);
      add_row(CMD_ALLOC, 4096, 1, 0, 0, 1, 1, 0, 4096);
      add_row(CMD_FREE, 8191, 0, 0, top_page, 1, 0, 0, 0);
      add_row(CMD_FREE, 10, 0, 0, 100, 0, 0, 0, 0);
      add_row(CMD_FREE, 5, 0, 0, 200, 0, 0, 0, 0);
      add_row(CMD_ALLOC, 20, 0, 105, 0, 0, 0, 0, 0);
      add_row(CMD_ALLOC, 4, 1, 0, 0, 0, 0, 0, 0);
      add_row(CMD_ALLOC, 8, 1, 0, 0, 0, 0, 0, 0);
      add_row(CMD_FREE, 8191, 0, 0, 4090, 0, 0, 0, 0);
      add_row(CMD_ALLOC, 3, 0, 1, 0, 0, 0, 0, 0);
      add_row(CMD_ALLOC, 3, 0, top_page, 0, 0, 0, 0, 0);
      add_row(CMD_ALLOC, 8191, 1, top_page, 0, 0, 0, 0, 0);
      add_row(CMD_FREE, 4096, 1, top_page, 0, 0, 0, 0, 0);
      add_row(CMD_ALLOC, 2, 0, 0, top_page, 0, 0, 0, 0);
      foreach (directed_rows[i]) begin
         send_cmd(directed_rows[i].cmd, directed_rows[i].known,
                  directed_rows[i].answer);
         idle_gap(1);
      end

      for (int phase = 0; phase < 14; phase++) begin
         wait_drained();
         base_val = PAGE_W'({$urandom, $urandom});
         if ($urandom_range(0, 3) == 0)
            base_val = PAGE_W'($urandom_range(0, 300));
         pages_val = PAGE_W'($urandom_range(1, 256));
         n_items = 100;
         case (phase)
            0: begin
               base_val = '0;
               pages_val = PAGE_W'(SEG_PAGES_RESET);
               n_items = 40;
            end
            1: begin
               base_val = PAGE_W'(top_page);
               pages_val = PAGE_W'(SEG_PAGES_RESET);
               n_items = 40;
            end
            2: begin
               pages_val = '0;
               n_items = 20;
            end
            3: begin
               pages_val = PAGE_W'({$urandom, $urandom});
               pages_val[COUNT_W-1:0] = '1;
               n_items = 30;
            end
            4: pages_val = PAGE_W'(1);
            default: ;
         endcase
         write_csr(REG_BASE, base_val);
         write_csr(REG_PAGES, pages_val);
         for (int k = 0; k < n_items; k++) begin
            c = random_cmd();
            send_cmd(c, 0, none);
            idle_gap(phase != 13);
         end
      end

      start <= 1'b0;
      while (pending_grants.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
